/* hdl/rme_pkg.sv */
// Shared constants, types and command/status structs of the running mean and error core.
`default_nettype none
package rme_pkg;

  // Default block limit and fixed field widths.
  localparam int unsigned RME_MAX_BLOCKS = 4096;
  localparam int unsigned AVG_W  = 32;
  localparam int unsigned SQ_W   = 31;
  localparam int unsigned ERR_W  = 31;
  localparam int unsigned SEEN_W = 13;
  localparam int unsigned ROOT_W = 48;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MSQ_GO,
    ST_MSQ_WAIT,
    ST_SQUARE,
    ST_CHECK,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DONE
  } rme_state_t;

  // Which quotient the shared divider works on.
  typedef enum logic [1:0] {
    DSEL_MEAN,
    DSEL_MSQ,
    DSEL_VAR
  } rme_dsel_t;

  typedef struct packed {
    logic      acc;
    logic      div_go;
    logic      div_take;
    rme_dsel_t dsel;
    logic      square;
    logic      root_go;
    logic      root_take;
    logic      load_out;
  } rme_cmd_t;

  typedef struct packed {
    logic div_done;
    logic root_done;
    logic var_ok;
    logic out_busy;
  } rme_stat_t;

endpackage
`default_nettype wire

/* hdl/rme_div.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none
module rme_div #(
  parameter int unsigned NUM_W = 44,
  parameter int unsigned DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_r, quot_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

/* hdl/rme_dp.sv */
// Datapath: running sums, shared divider, square, bitwise square root and result register.
`default_nettype none
module rme_dp #(
  parameter int unsigned MAX_BLOCKS = rme_pkg::RME_MAX_BLOCKS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [rme_pkg::AVG_W-1:0]     in_block_average,
  input  wire logic        [rme_pkg::SQ_W-1:0]      in_block_average_sq,
  input  wire logic                                 in_first_of_run,
  input  wire rme_pkg::rme_cmd_t                    cmd,
  output rme_pkg::rme_stat_t                        stat,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic signed [rme_pkg::AVG_W-1:0]          out_progressive_mean,
  output logic        [rme_pkg::ERR_W-1:0]          out_mean_error,
  output logic        [rme_pkg::SEEN_W-1:0]         out_blocks_seen,
  output logic                                      out_full_res
);
  import rme_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = SQ_W + CNT_W;

  logic signed [SUM_W-1:0]  asum_r;
  logic        [SUM_W-1:0]  qsum_r;
  logic        [CNT_W-1:0]  cnt_r;
  logic                     full_r;
  logic signed [SUM_W-1:0]  asum_base;
  logic        [SUM_W-1:0]  qsum_base;
  logic        [CNT_W-1:0]  cnt_base;
  logic                     full;
  logic        [SUM_W-1:0]  asum_mag;

  logic signed [AVG_W-1:0]  mean_r;
  logic        [AVG_W-1:0]  amean_r;
  logic        [AVG_W-1:0]  msq_r;
  logic        [ROOT_W-1:0] mean2_r;
  logic        [SQ_W-1:0]   var_r;
  logic        [ERR_W-1:0]  err_r;
  logic        [2*AVG_W-1:0] prod;
  logic        [AVG_W-1:0]  diff;

  logic        [SUM_W-1:0]  div_num;
  logic        [CNT_W-1:0]  div_den;
  logic                     div_busy;
  logic                     div_done;
  logic        [SUM_W-1:0]  div_quot;

  logic        [ROOT_W-1:0] x_r;
  logic        [ROOT_W-1:0] res_r;
  logic        [ROOT_W-1:0] bit_r;
  logic                     root_busy_r;
  logic                     root_done_r;
  logic        [ROOT_W-1:0] trial;

  logic signed [AVG_W-1:0]  out_mean_r;
  logic        [ERR_W-1:0]  out_err_r;
  logic        [SEEN_W-1:0] out_cnt_r;
  logic                     out_full_r;
  logic                     out_valid_r;

  // A first block of a run starts from empty sums; a full store takes nothing more.
  always_comb begin
    asum_base = in_first_of_run ? '0 : asum_r;
    qsum_base = in_first_of_run ? '0 : qsum_r;
    cnt_base  = in_first_of_run ? '0 : cnt_r;
    full      = cnt_base >= CNT_W'(MAX_BLOCKS);
    asum_mag  = asum_r[SUM_W-1] ? SUM_W'(-asum_r) : SUM_W'(asum_r);
  end

  // Running sums and block count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asum_r <= '0;
      qsum_r <= '0;
      cnt_r  <= '0;
      full_r <= 1'b0;
    end else if (cmd.acc) begin
      full_r <= full;
      if (full) begin
        asum_r <= asum_base;
        qsum_r <= qsum_base;
        cnt_r  <= cnt_base;
      end else begin
        asum_r <= asum_base + {{(SUM_W-AVG_W){in_block_average[AVG_W-1]}}, in_block_average};
        qsum_r <= qsum_base + {{(SUM_W-SQ_W){1'b0}}, in_block_average_sq};
        cnt_r  <= cnt_base + 1'b1;
      end
    end
  end

  // Operand selection for the shared divider.
  always_comb begin
    diff = msq_r - mean2_r[AVG_W-1:0];
    unique case (cmd.dsel)
      DSEL_MEAN: begin
        div_num = asum_mag;
        div_den = cnt_r;
      end
      DSEL_MSQ: begin
        div_num = qsum_r;
        div_den = cnt_r;
      end
      DSEL_VAR: begin
        div_num = {{(SUM_W-AVG_W){1'b0}}, diff};
        div_den = cnt_r - 1'b1;
      end
      default: begin
        div_num = '0;
        div_den = cnt_r;
      end
    endcase
  end

  rme_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  assign prod = amean_r * amean_r;

  // Quotients, the squared mean and the error.
  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      case (cmd.dsel)
        DSEL_MEAN: begin
          amean_r <= div_quot[AVG_W-1:0];
          mean_r  <= asum_r[SUM_W-1] ? -div_quot[AVG_W-1:0] : div_quot[AVG_W-1:0];
        end
        DSEL_MSQ: msq_r <= div_quot[AVG_W-1:0];
        default:  var_r <= div_quot[SQ_W-1:0];
      endcase
    end
    if (cmd.square) begin
      mean2_r <= prod[2*AVG_W-1:16];
    end
    if (cmd.acc) begin
      err_r <= '0;
    end else if (cmd.root_take) begin
      err_r <= res_r[ERR_W-1:0];
    end
  end

  // Bitwise integer square root, one result bit per cycle.
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_busy_r <= 1'b0;
      root_done_r <= 1'b0;
    end else begin
      root_done_r <= 1'b0;
      if (cmd.root_go) begin
        root_busy_r <= 1'b1;
      end else if (root_busy_r && bit_r[0]) begin
        root_busy_r <= 1'b0;
        root_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_go) begin
      x_r   <= {1'b0, var_r, 16'b0};
      res_r <= '0;
      bit_r <= ROOT_W'(1) << (ROOT_W - 2);
    end else if (root_busy_r) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Result register; the next block may be taken while a beat waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mean_r <= mean_r;
      out_err_r  <= err_r;
      out_cnt_r  <= SEEN_W'(cnt_r);
      out_full_r <= full_r;
    end
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.root_done = root_done_r;
    stat.var_ok    = (cnt_r > CNT_W'(1)) && ({16'b0, msq_r} > mean2_r);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid            = out_valid_r;
  assign out_progressive_mean = out_mean_r;
  assign out_mean_error       = out_err_r;
  assign out_blocks_seen      = out_cnt_r;
  assign out_full_res         = out_full_r;

  // The divider and the root unit never run at once.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy && root_busy_r)) else $error("divider and root unit both busy");

  // A loaded result is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r) else $error("loaded result not valid");

  // The root unit starts only from idle.
  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_go |-> !root_busy_r) else $error("root unit restarted while busy");

endmodule
`default_nettype wire

/* hdl/rme_ctrl.sv */
// Controller state machine that sequences the datapath for each block.
`default_nettype none
module rme_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rme_pkg::rme_stat_t stat,
  output rme_pkg::rme_cmd_t       cmd
);
  import rme_pkg::*;

  rme_state_t state_r;
  rme_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.dsel  = DSEL_MEAN;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc   = 1'b1;
          state_nxt = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_MSQ_GO;
        end
      end
      ST_MSQ_GO: begin
        cmd.dsel   = DSEL_MSQ;
        cmd.div_go = 1'b1;
        state_nxt  = ST_MSQ_WAIT;
      end
      ST_MSQ_WAIT: begin
        cmd.dsel = DSEL_MSQ;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.var_ok ? ST_VAR_GO : ST_DONE;
      end
      ST_VAR_GO: begin
        cmd.dsel   = DSEL_VAR;
        cmd.div_go = 1'b1;
        state_nxt  = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        cmd.dsel = DSEL_VAR;
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        cmd.root_go = 1'b1;
        state_nxt   = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (stat.root_done) begin
          cmd.root_take = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A beat is taken only when no block is in progress.
  a_acc_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> state_r == ST_MEAN_GO) else $error("accumulate outside idle");

  // A result is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_busy) else $error("result overwritten");

endmodule
`default_nettype wire

/* hdl/blocking_running_mean_error_core.sv */
// Each accepted block runs through the shared bit-per-cycle divider (mean, mean square and
// variance) and the bit-per-cycle square root. A block whose count is one or less, or whose
// mean square does not exceed the squared mean, skips the variance division and the root.
// A new block is taken only in idle, once the previous result has been loaded for output.
// A finished result waits in the output register while the next block is taken.
// Reset (rst_n, synchronous, active low) clears the sums, the count and all handshake state.
`default_nettype none
module blocking_running_mean_error_core #(
  parameter int unsigned MAX_BLOCKS = rme_pkg::RME_MAX_BLOCKS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [rme_pkg::AVG_W-1:0] in_block_average,
  input  wire logic        [rme_pkg::SQ_W-1:0]  in_block_average_sq,
  input  wire logic                             in_first_of_run,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [rme_pkg::AVG_W-1:0]      out_progressive_mean,
  output logic        [rme_pkg::ERR_W-1:0]      out_mean_error,
  output logic        [rme_pkg::SEEN_W-1:0]     out_blocks_seen,
  output logic                                  out_full_res
);
  import rme_pkg::*;

  rme_cmd_t  cmd;
  rme_stat_t stat;

  rme_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rme_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_block_average    (in_block_average),
    .in_block_average_sq (in_block_average_sq),
    .in_first_of_run     (in_first_of_run),
    .cmd                 (cmd),
    .stat                (stat),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_progressive_mean(out_progressive_mean),
    .out_mean_error      (out_mean_error),
    .out_blocks_seen     (out_blocks_seen),
    .out_full_res        (out_full_res)
  );

endmodule
`default_nettype wire
